### hdl/dpfp_pkg.sv
// ----------------------------------------------------------------------------
// dpfp_pkg: shared constants of the decimal price parser
// ASCII codes of the price syntax, the signed 64-bit magnitude limit and the
// default number of fraction digits
// ----------------------------------------------------------------------------
package dpfp_pkg;

  localparam int unsigned DEFAULT_FRACTION_DIGITS = 4;

  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [7:0] CHAR_POINT = 8'h2e;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // largest magnitude allowed for either sign
  localparam logic [63:0] POS_LIMIT = 64'h7fff_ffff_ffff_ffff;

endpackage

### hdl/decimal_price_to_fixed_point_parser.sv
// ----------------------------------------------------------------------------
// decimal_price_to_fixed_point_parser: ASCII price field to fixed point
// Parses one price field, a character per transaction, into a signed value
// scaled by ten to the FRACTION_DIGITS, with an error flag
// ----------------------------------------------------------------------------
// usage
//   item channel (item_valid / item_ready): one character per transaction;
//   has_char marks the character as part of the field, end_of_field closes
//   the field (an end with no character before it is an empty field)
//   result channel (result_valid / result_ready): one transaction per field,
//   price_value and parse_error; the value is zero whenever parse_error is set
// throughput and stages
//   one transaction per cycle is taken while item_ready is high; the field
//   state of a closing transaction is snapshotted into a finish register on
//   the accepting edge, then whole part and fraction are summed, range
//   checked and signed into the result register once that register is free
// reset
//   synchronous rst clears the field state and empties both stages
// stalls
//   a held result keeps its value; the finish register still takes one more
//   closed field, after which item_ready drops until result_ready frees a slot
// ----------------------------------------------------------------------------
module decimal_price_to_fixed_point_parser #(
  parameter int unsigned FRACTION_DIGITS = dpfp_pkg::DEFAULT_FRACTION_DIGITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  logic [7:0]         character,
  input  logic               has_char,
  input  logic               end_of_field,
  output logic               result_valid,
  input  logic               result_ready,
  output logic signed [63:0] price_value,
  output logic               parse_error
);
  import dpfp_pkg::*;

  // scale and the largest whole part that still fits after scaling
  localparam logic [63:0] SCALE  = 64'd10 ** FRACTION_DIGITS;
  localparam logic [63:0] WMAX   = POS_LIMIT / SCALE;
  localparam int unsigned FRAC_W = $clog2(SCALE);
  localparam int unsigned CNT_W  = $clog2(FRACTION_DIGITS + 1);
  localparam int unsigned WGT_N  = 2 ** CNT_W;

  // field state; the whole part is kept already multiplied by SCALE
  logic              at_start;
  logic              is_neg;
  logic              seen_point;
  logic              have_whole;
  logic [62:0]       whole;
  logic [FRAC_W-1:0] frac;
  logic [CNT_W-1:0]  frac_cnt;
  logic              err;

  logic              at_start_next;
  logic              is_neg_next;
  logic              seen_point_next;
  logic              have_whole_next;
  logic [62:0]       whole_next;
  logic [FRAC_W-1:0] frac_next;
  logic [CNT_W-1:0]  frac_cnt_next;
  logic              err_next;
  logic              field_err;

  // finish stage
  logic              fin_valid;
  logic [62:0]       fin_whole;
  logic [FRAC_W-1:0] fin_frac;
  logic              fin_neg;
  logic              fin_err;

  logic              accept;
  logic              out_load;

  // constant tables: digit times SCALE, whole-part limit per digit (scaled),
  // and the place weight of each fraction digit (already right-padded)
  logic [62:0]       digit_weight [16];
  logic [62:0]       whole_limit  [16];
  logic [FRAC_W-1:0] frac_weight  [WGT_N];

  for (genvar g = 0; g < 16; g++) begin : g_digit_tab
    if (g < 10) begin : g_used
      localparam logic [63:0] DW  = 64'(g) * SCALE;
      localparam logic [63:0] LIM = ((WMAX - 64'(g)) / 64'd10) * SCALE;
      assign digit_weight[g] = DW[62:0];
      assign whole_limit[g]  = LIM[62:0];
    end else begin : g_unused
      assign digit_weight[g] = '0;
      assign whole_limit[g]  = '0;
    end
  end

  for (genvar g = 0; g < WGT_N; g++) begin : g_frac_tab
    if (g < FRACTION_DIGITS) begin : g_used
      localparam logic [63:0] FW = 64'd10 ** (FRACTION_DIGITS - 1 - g);
      assign frac_weight[g] = FW[FRAC_W-1:0];
    end else begin : g_unused
      assign frac_weight[g] = '0;
    end
  end

  // handshake: the finish register is the only slot the input waits on
  assign out_load   = fin_valid && (!result_valid || result_ready);
  assign item_ready = !fin_valid || out_load;
  assign accept     = item_valid && item_ready;

  // character decode and state update
  logic              is_digit;
  logic [3:0]        digit;
  logic [62:0]       whole_x10;
  logic [FRAC_W+3:0] frac_prod;

  assign is_digit  = (character >= CHAR_ZERO) && (character <= CHAR_NINE);
  assign digit     = character[3:0];
  assign whole_x10 = {whole[59:0], 3'b000} + {whole[61:0], 1'b0} + digit_weight[digit];
  assign frac_prod = (FRAC_W + 4)'(digit) * (FRAC_W + 4)'(frac_weight[frac_cnt]);

  always_comb begin
    at_start_next   = at_start;
    is_neg_next     = is_neg;
    seen_point_next = seen_point;
    have_whole_next = have_whole;
    whole_next      = whole;
    frac_next       = frac;
    frac_cnt_next   = frac_cnt;
    err_next        = err;
    if (has_char) begin
      at_start_next = 1'b0;
      if (!err) begin
        if (is_digit) begin
          if (!seen_point) begin
            // would exceed the largest whole part for this scale
            if (whole > whole_limit[digit]) begin
              err_next = 1'b1;
            end else begin
              whole_next = whole_x10;
            end
            have_whole_next = 1'b1;
          end else if (frac_cnt >= CNT_W'(FRACTION_DIGITS)) begin
            err_next = 1'b1;
          end else begin
            frac_next     = frac + frac_prod[FRAC_W-1:0];
            frac_cnt_next = frac_cnt + 1'b1;
          end
        end else if (character == CHAR_MINUS && at_start) begin
          is_neg_next = 1'b1;
        end else if (character == CHAR_PLUS && at_start) begin
          is_neg_next = is_neg;
        end else if (character == CHAR_POINT) begin
          if (seen_point || !have_whole) begin
            err_next = 1'b1;
          end else begin
            seen_point_next = 1'b1;
          end
        end else begin
          err_next = 1'b1;
        end
      end
    end
  end

  // parse error, empty field, sign only or no whole digits
  assign field_err = err_next || at_start_next || !have_whole_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start   <= 1'b1;
      is_neg     <= 1'b0;
      seen_point <= 1'b0;
      have_whole <= 1'b0;
      whole      <= '0;
      frac       <= '0;
      frac_cnt   <= '0;
      err        <= 1'b0;
    end else if (accept) begin
      if (end_of_field) begin
        // field closed: start the next one clean
        at_start   <= 1'b1;
        is_neg     <= 1'b0;
        seen_point <= 1'b0;
        have_whole <= 1'b0;
        whole      <= '0;
        frac       <= '0;
        frac_cnt   <= '0;
        err        <= 1'b0;
      end else begin
        at_start   <= at_start_next;
        is_neg     <= is_neg_next;
        seen_point <= seen_point_next;
        have_whole <= have_whole_next;
        whole      <= whole_next;
        frac       <= frac_next;
        frac_cnt   <= frac_cnt_next;
        err        <= err_next;
      end
    end
  end

  // finish register: snapshot of a closed field
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (accept && end_of_field) begin
      fin_valid <= 1'b1;
    end else if (out_load) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && end_of_field) begin
      fin_whole <= whole_next;
      fin_frac  <= frac_next;
      fin_neg   <= is_neg_next;
      fin_err   <= field_err;
    end
  end

  // sum, range check and sign; the negative form is built alongside the sum
  logic [63:0] sum_pos;
  logic [63:0] sum_neg;
  logic        range_err;
  logic        fin_bad;

  assign sum_pos   = {1'b0, fin_whole} + 64'(fin_frac);
  assign sum_neg   = ~{1'b0, fin_whole} + ~64'(fin_frac) + 64'd2;
  assign range_err = sum_pos[63];
  assign fin_bad   = fin_err || range_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      parse_error <= fin_bad;
      if (fin_bad) begin
        price_value <= '0;
      end else if (fin_neg) begin
        price_value <= sum_neg;
      end else begin
        price_value <= sum_pos;
      end
    end
  end

  // a stalled finish register keeps its field
  a_fin_hold: assert property (@(posedge clk) disable iff (rst)
    fin_valid && !out_load |=> fin_valid && $stable(fin_whole) && $stable(fin_frac))
    else $error("finish register lost a field while stalled");

  // an error result always carries zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && parse_error |-> price_value == 64'sd0)
    else $error("error result with non-zero value");

  // a closed field leaves clean state and a pending finish
  a_field_clear: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_field |=> at_start && !err && fin_valid)
    else $error("field state not cleared after field end");

  // fraction digit count stays within the scale
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    frac_cnt <= CNT_W'(FRACTION_DIGITS))
    else $error("fraction digit count out of range");

  // a point is only taken after a whole digit
  a_point_order: assert property (@(posedge clk) disable iff (rst)
    seen_point |-> have_whole && !at_start)
    else $error("point recorded without whole digits");

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: decimal price parser check
// Streams price fields, directed and random, into the parser one character
// per transaction and checks every price against an in-bench parser, with
// random idling on both channels and a long hold-off on the result side
// ----------------------------------------------------------------------------

// expected price of one field
typedef struct {
  logic signed [63:0] value;
  logic               error;
} price_result_t;

class price_scoreboard;
  localparam int unsigned FD = dpfp_pkg::DEFAULT_FRACTION_DIGITS;

  logic [63:0]   scale;
  logic [63:0]   whole_max;
  price_result_t expected_prices[$];
  int            mismatch_count;

  // parser state of the field in progress
  bit          field_start;
  bit          negative;
  bit          point_seen;
  bit          whole_seen;
  bit          error_flag;
  logic [63:0] whole_acc;
  logic [63:0] frac_acc;
  int unsigned frac_count;

  function new();
    scale = 64'd1;
    for (int unsigned i = 0; i < FD; i++) scale = scale * 64'd10;
    whole_max = dpfp_pkg::POS_LIMIT / scale;
    mismatch_count = 0;
    clear_field();
  endfunction

  function void clear_field();
    field_start = 1'b1;
    negative    = 1'b0;
    point_seen  = 1'b0;
    whole_seen  = 1'b0;
    error_flag  = 1'b0;
    whole_acc   = '0;
    frac_acc    = '0;
    frac_count  = 0;
  endfunction

  function void parse_char(logic [7:0] ch);
    bit          first;
    logic [63:0] digit;
    first = field_start;
    field_start = 1'b0;
    if (error_flag) return;
    if (ch >= dpfp_pkg::CHAR_ZERO && ch <= dpfp_pkg::CHAR_NINE) begin
      digit = 64'(ch - dpfp_pkg::CHAR_ZERO);
      if (!point_seen) begin
        // whole * 10 + digit must stay within the whole-part limit
        if (whole_acc > (whole_max - digit) / 64'd10) error_flag = 1'b1;
        else whole_acc = whole_acc * 64'd10 + digit;
        whole_seen = 1'b1;
      end else if (frac_count >= FD) begin
        error_flag = 1'b1;
      end else begin
        frac_acc = frac_acc * 64'd10 + digit;
        frac_count++;
      end
    end else if (ch == dpfp_pkg::CHAR_MINUS && first) begin
      negative = 1'b1;
    end else if (ch == dpfp_pkg::CHAR_PLUS && first) begin
      // plus sign changes nothing
    end else if (ch == dpfp_pkg::CHAR_POINT) begin
      if (point_seen || !whole_seen) error_flag = 1'b1;
      else point_seen = 1'b1;
    end else begin
      error_flag = 1'b1;
    end
  endfunction

  // accepted item transaction: advance the parser, predict on field end
  function void take_item(logic [7:0] ch, logic has_char, logic end_of_field);
    price_result_t r;
    logic [63:0]   frac;
    logic [63:0]   base;
    if (has_char) parse_char(ch);
    if (!end_of_field) return;
    r.error = error_flag || field_start || !whole_seen;
    r.value = '0;
    if (!r.error) begin
      frac = frac_acc;
      for (int unsigned i = frac_count; i < FD; i++) frac = frac * 64'd10;
      base = whole_acc * scale;
      if (frac > dpfp_pkg::POS_LIMIT - base) begin
        r.error = 1'b1;
      end else begin
        r.value = base + frac;
        if (negative) r.value = -r.value;
      end
    end
    expected_prices.push_back(r);
    clear_field();
  endfunction

  task report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // accepted result transaction against the oldest expected price
  task check_price(logic signed [63:0] value, logic error);
    price_result_t r;
    if (expected_prices.size() == 0) begin
      report($sformatf("price %0d error %b with no field pending", value, error));
      return;
    end
    r = expected_prices.pop_front();
    if (value !== r.value)
      report($sformatf("price_value %0d, expected %0d", value, r.value));
    if (error !== r.error)
      report($sformatf("parse_error %b, expected %b", error, r.error));
  endtask
endclass

module testbench;
  import dpfp_pkg::*;

  localparam int unsigned FD              = DEFAULT_FRACTION_DIGITS;
  localparam int          ITEM_TARGET     = 900;
  localparam int          QUIET_FROM      = 780;  // no idling past this many items
  localparam int          HOLD_OFF_CYCLES = 60;
  localparam int          WATCHDOG_LIMIT  = 2000;
  localparam int          DRAIN_CYCLES    = 10;

  logic               clk;
  logic               rst;
  logic               item_valid;
  logic               item_ready;
  logic [7:0]         character;
  logic               has_char;
  logic               end_of_field;
  logic               result_valid;
  logic               result_ready;
  logic signed [63:0] price_value;
  logic               parse_error;

  price_scoreboard price_board = new();

  int items_sent      = 0;
  int tx_idle_pct     = 0;
  int rx_idle_pct     = 0;
  int stalled_cycles  = 0;
  bit hold_off_request = 1'b0;

  decimal_price_to_fixed_point_parser #(
    .FRACTION_DIGITS(FD)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .character   (character),
    .has_char    (has_char),
    .end_of_field(end_of_field),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .price_value (price_value),
    .parse_error (parse_error)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // both channels sampled on the edge, before the block's registers move
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && item_ready)
        price_board.take_item(character, has_char, end_of_field);
      if (result_valid && result_ready)
        price_board.check_price(price_value, parse_error);
    end
  end

  // watchdog: too many cycles in a row with no transaction on either side
  initial begin
    while (stalled_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((item_valid && item_ready) || (result_valid && result_ready))
        stalled_cycles = 0;
      else
        stalled_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // result side: idle bursts, one long hold-off on request, otherwise ready
  initial begin
    result_ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (hold_off_request) begin
        // hold long enough for the block to fill and stall its item side
        result_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_request = 1'b0;
      end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end else begin
        result_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // one item transaction, with an optional idle burst in front
  task automatic send_item(logic [7:0] ch, logic with_char, logic last);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    item_valid   <= 1'b1;
    character    <= ch;
    has_char     <= with_char;
    end_of_field <= last;
    do @(posedge clk); while (!item_ready);
    if (with_char || last) items_sent++;
  endtask

  // whole field; the end either rides on the last character or comes alone
  task automatic send_field(logic [7:0] chars[$], bit separate_end);
    for (int i = 0; i < chars.size(); i++) begin
      // ignored item with neither character nor end, now and then
      if ($urandom_range(99) < 5) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
      send_item(chars[i], 1'b1, !separate_end && i == chars.size() - 1);
    end
    if (separate_end || chars.size() == 0)
      send_item(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  task automatic send_text(string text, bit separate_end);
    logic [7:0] chars[$];
    for (int i = 0; i < text.len(); i++) chars.push_back(text[i]);
    send_field(chars, separate_end);
  endtask

  initial begin
    logic [7:0]  field[$];
    logic [7:0]  limit_whole[$];
    logic [7:0]  limit_frac[$];
    logic [7:0]  noise_set[$];
    string       limit_digits;
    logic [63:0] remainder;
    logic [63:0] place;
    int          kind;
    int          len;
    int          pos;
    int          fields_done;

    rst          <= 1'b1;
    item_valid   <= 1'b0;
    character    <= '0;
    has_char     <= 1'b0;
    end_of_field <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // digits of the largest magnitude, split into whole part and fraction
    limit_digits = $sformatf("%0d", POS_LIMIT / price_board.scale);
    for (int i = 0; i < limit_digits.len(); i++) limit_whole.push_back(limit_digits[i]);
    remainder = POS_LIMIT % price_board.scale;
    place = price_board.scale / 64'd10;
    for (int unsigned i = 0; i < FD; i++) begin
      limit_frac.push_back(CHAR_ZERO + 8'((remainder / place) % 64'd10));
      place = place / 64'd10;
    end
    noise_set = {CHAR_MINUS, CHAR_PLUS, CHAR_POINT, CHAR_ZERO, CHAR_NINE, 8'h00, 8'hff};

    // directed fields
    tx_idle_pct = 20;
    rx_idle_pct = 20;
    send_text("", 1'b0);                          // empty field
    send_item(8'h00, 1'b0, 1'b0);                 // neither character nor end
    send_text("-0", 1'b1);                        // minus zero, end on its own
    send_text("+9.", 1'b0);                       // plus sign and trailing point
    send_text("-", 1'b0);                         // sign only
    send_text(".5", 1'b0);                        // no whole digit before point
    send_text("1..", 1'b0);                       // second point, rest ignored
    send_text("-+1", 1'b0);                       // sign not first
    field = {CHAR_ZERO + 8'd1, 8'hff};            // byte outside the syntax
    send_field(field, 1'b0);
    send_text("0.12345", 1'b0);                   // one fraction digit too many

    // fill the block while the result side holds off
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_off_request = 1'b1;
    repeat (24) begin
      field.delete();
      field.push_back(CHAR_ZERO + 8'($urandom_range(9)));
      send_field(field, 1'b0);
    end

    // random fields, mostly well formed
    fields_done = 0;
    while (items_sent < ITEM_TARGET) begin
      if (fields_done % 40 == 0) begin
        tx_idle_pct = $urandom_range(2) * 20;
        rx_idle_pct = $urandom_range(2) * 20;
      end
      if (items_sent > QUIET_FROM) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end

      field.delete();
      kind = $urandom_range(99);
      if (kind < 65 || kind >= 90) begin
        // well formed: sign, whole digits, optional point and fraction
        case ($urandom_range(2))
          1: field.push_back(CHAR_MINUS);
          2: field.push_back(CHAR_PLUS);
          default: ;
        endcase
        len = ($urandom_range(9) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
        repeat (len) field.push_back(CHAR_ZERO + 8'($urandom_range(9)));
        if ($urandom_range(99) < 60) begin
          field.push_back(CHAR_POINT);
          repeat ($urandom_range(FD)) field.push_back(CHAR_ZERO + 8'($urandom_range(9)));
        end
        // broken: a stray byte or syntax character put in at random
        if (kind >= 90) begin
          pos = $urandom_range(field.size());
          if ($urandom_range(1) == 0)
            field.insert(pos, 8'($urandom_range(255)));
          else
            field.insert(pos, noise_set[$urandom_range(2)]);
        end
      end else if (kind < 77) begin
        // around the range limit, either sign
        if ($urandom_range(1) == 0) field.push_back(CHAR_MINUS);
        field = {field, limit_whole};
        case ($urandom_range(5))
          0: if (field[field.size() - 1] < CHAR_NINE)
               field[field.size() - 1] = field[field.size() - 1] + 8'd1;
          1: field.push_back(CHAR_ZERO + 8'($urandom_range(9)));
          default: ;
        endcase
        if ($urandom_range(3) != 0) begin
          field.push_back(CHAR_POINT);
          case ($urandom_range(3))
            0, 1: field = {field, limit_frac};
            2: begin
              field = {field, limit_frac};
              if (field[field.size() - 1] < CHAR_NINE)
                field[field.size() - 1] = field[field.size() - 1] + 8'd1;
            end
            default: repeat (FD) field.push_back(CHAR_ZERO + 8'($urandom_range(9)));
          endcase
        end
      end else if (kind < 84) begin
        // noise: random bytes, leaning on the syntax characters
        len = $urandom_range(6);
        repeat (len) begin
          if ($urandom_range(1) == 0) field.push_back(8'($urandom_range(255)));
          else field.push_back(noise_set[$urandom_range(noise_set.size() - 1)]);
        end
      end else begin
        // short malformed shapes: sign only, point first, too long a fraction, empty
        case ($urandom_range(3))
          0: field.push_back(noise_set[$urandom_range(1)]);
          1: begin
            field.push_back(CHAR_POINT);
            field.push_back(CHAR_ZERO + 8'($urandom_range(9)));
          end
          2: begin
            field.push_back(CHAR_ZERO + 8'($urandom_range(9)));
            field.push_back(CHAR_POINT);
            repeat (FD + 1) field.push_back(CHAR_ZERO + 8'($urandom_range(9)));
          end
          default: ;
        endcase
      end

      send_field(field, $urandom_range(3) == 0);
      fields_done++;
    end
    item_valid <= 1'b0;

    // drain outstanding prices, then allow for the pipeline
    while (price_board.expected_prices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (price_board.expected_prices.size() != 0)
      price_board.report("prices still outstanding at the end");

    if (price_board.mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/dpfp_pkg.sv
hdl/decimal_price_to_fixed_point_parser.sv
bench/testbench.sv
